// ----- rtl/erf_pkg.sv -----
package erf_pkg;

    // Default fixed-point formats of the ports
    localparam int IN_FRAC_BITS_DEF  = 12;
    localparam int OUT_FRAC_BITS_DEF = 15;

    // Internal Q30 arithmetic
    localparam int FX_FRAC = 30;
    localparam int MAG_W   = 17;             // |x| up to 32768
    localparam int T_W     = 31;             // unsigned Q30 up to 1.0
    localparam int DEN_W   = 36;             // 1 + p*|x| for the smallest input format
    localparam int REM_W   = 61;             // dividend 2^60 + denom/2
    localparam int PS_W    = 34;             // signed Horner accumulator
    localparam int PM_W    = 32;             // Horner magnitude
    localparam int P_W     = 32;             // clamped polynomial
    localparam int R_W     = 29;             // reduced exp argument
    localparam int M_W     = 30;             // reciprocal multiplier for the Taylor divide
    localparam int EXP_TERMS     = 8;
    localparam int SQUARINGS     = 6;
    localparam int EXP_PRE_SHIFT = 6;
    localparam int OUT_W   = 16;
    localparam int OUT_MAX = 32767;

    localparam logic [63:0] FX_ONE64 = 64'd1 << FX_FRAC;
    localparam logic [63:0] FX_HALF  = 64'd1 << (FX_FRAC - 1);
    localparam logic [T_W-1:0] FX_ONE = T_W'(FX_ONE64);

    // Coefficients, rounded half up to Q30
    localparam logic [28:0] K_P =
        29'((64'd3275911 * FX_ONE64 + 64'd5000000) / 64'd10000000);
    localparam logic [T_W-1:0] K_A1 =
        T_W'((64'd254829592 * FX_ONE64 + 64'd500000000) / 64'd1000000000);
    localparam logic [T_W-1:0] K_A2 =
        T_W'((64'd284496736 * FX_ONE64 + 64'd500000000) / 64'd1000000000);
    localparam logic [T_W-1:0] K_A3 =
        T_W'((64'd1421413741 * FX_ONE64 + 64'd500000000) / 64'd1000000000);
    localparam logic [T_W-1:0] K_A4 =
        T_W'((64'd1453152027 * FX_ONE64 + 64'd500000000) / 64'd1000000000);
    localparam logic [T_W-1:0] K_A5 =
        T_W'((64'd1061405429 * FX_ONE64 + 64'd500000000) / 64'd1000000000);

    // Sign and magnitude of the argument
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } erf_side_t;

    // What rides along the exponential pipeline
    typedef struct packed {
        logic           neg;
        logic           big;
        logic [P_W-1:0] p;
    } erf_carry_t;

    // Constant added after each Horner product
    function automatic logic signed [PS_W-1:0] horner_coef(input int s);
        logic signed [PS_W-1:0] c;
        unique case (s)
            0:       c = -$signed(PS_W'(K_A4));
            1:       c =  $signed(PS_W'(K_A3));
            2:       c = -$signed(PS_W'(K_A2));
            3:       c =  $signed(PS_W'(K_A1));
            default: c = '0;
        endcase
        return c;
    endfunction

    // floor(v/k) = (v*M) >> m, exact for v < 2^29
    function automatic logic [M_W-1:0] recip_mult(input int k);
        logic [M_W-1:0] m;
        unique case (k)
            3:       m = 30'd715827883;
            5:       m = 30'd858993460;
            6:       m = 30'd715827883;
            7:       m = 30'd613566757;
            default: m = 30'd536870912;
        endcase
        return m;
    endfunction

    function automatic int recip_shift(input int k);
        int sh;
        unique case (k)
            1:       sh = 29;
            2:       sh = 30;
            3:       sh = 31;
            4:       sh = 31;
            default: sh = 32;
        endcase
        return sh;
    endfunction

endpackage

// ----- rtl/erf_recip.sv -----
module erf_recip #(
    parameter int IN_FRAC_BITS = erf_pkg::IN_FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  erf_pkg::erf_side_t      in_side,
    output logic                    out_valid,
    output logic [erf_pkg::T_W-1:0] out_t,
    output erf_pkg::erf_side_t      out_side
);
    import erf_pkg::*;

    localparam int STEPS = T_W;
    localparam int CMP_W = DEN_W + T_W;

    logic [STEPS:0]     valid_reg;
    logic [REM_W-1:0]   rem_reg  [0:STEPS];
    logic [DEN_W-1:0]   den_reg  [0:STEPS];
    logic [T_W-1:0]     quo_reg  [0:STEPS];
    erf_side_t          side_reg [0:STEPS];

    logic [45:0]        kx;
    logic [DEN_W-1:0]   den_next;
    logic [REM_W-1:0]   num_next;

    // Form 1 + p*|x| and the rounding dividend 2^60 + denom/2
    assign kx       = 46'(K_P) * 46'(in_side.mag);
    assign den_next = DEN_W'(FX_ONE64) + DEN_W'(kx >> IN_FRAC_BITS);
    assign num_next = (REM_W'(1) << 60) + REM_W'(den_next >> 1);

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
        end
    end

    // Load the divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= num_next;
            den_reg[0]  <= den_next;
            quo_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        localparam int B = STEPS - 1 - j;
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] rem_ext;
        logic             take;

        assign dsh     = CMP_W'(den_reg[j]) << B;
        assign rem_ext = CMP_W'(rem_reg[j]);
        assign take    = rem_ext >= dsh;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1]  <= take ? REM_W'(rem_ext - dsh) : rem_reg[j];
                den_reg[j+1]  <= den_reg[j];
                quo_reg[j+1]  <= {quo_reg[j][T_W-2:0], take};
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_t     = quo_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

// ----- rtl/erf_poly.sv -----
module erf_poly (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [erf_pkg::T_W-1:0] in_t,
    input  erf_pkg::erf_side_t      in_side,
    output logic                    out_valid,
    output logic [erf_pkg::P_W-1:0] out_p,
    output erf_pkg::erf_side_t      out_side
);
    import erf_pkg::*;

    localparam int STEPS  = 5;
    localparam int PROD_W = PM_W + T_W;

    logic signed [PS_W-1:0] p_w    [0:STEPS];
    logic [T_W-1:0]         t_w    [0:STEPS];
    erf_side_t              side_w [0:STEPS];
    logic                   v_w    [0:STEPS];

    assign p_w[0]    = $signed(PS_W'(K_A5));
    assign t_w[0]    = in_t;
    assign side_w[0] = in_side;
    assign v_w[0]    = in_valid;

    // Each Horner step: multiply stage, then round and add stage
    for (genvar s = 0; s < STEPS; s++)
    begin : g_horner
        logic                   vm_reg;
        logic                   vr_reg;
        logic                   sg_reg;
        logic [PROD_W-1:0]      prod_reg;
        logic [T_W-1:0]         tm_reg;
        erf_side_t              sm_reg;
        logic signed [PS_W-1:0] p_reg;
        logic [T_W-1:0]         t_reg;
        erf_side_t              side_reg;

        logic [PM_W-1:0]        pmag;
        logic [PS_W-1:0]        rnd;
        logic signed [PS_W-1:0] sv;

        assign pmag = p_w[s][PS_W-1] ? PM_W'(-p_w[s]) : PM_W'(p_w[s]);
        assign rnd  = PS_W'((64'(prod_reg) + FX_HALF) >> FX_FRAC);
        assign sv   = sg_reg ? -$signed(rnd) : $signed(rnd);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vm_reg <= 1'b0;
                vr_reg <= 1'b0;
            end
            else if (adv)
            begin
                vm_reg <= v_w[s];
                vr_reg <= vm_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sg_reg   <= p_w[s][PS_W-1];
                prod_reg <= PROD_W'(pmag) * PROD_W'(t_w[s]);
                tm_reg   <= t_w[s];
                sm_reg   <= side_w[s];
                p_reg    <= sv + horner_coef(s);
                t_reg    <= tm_reg;
                side_reg <= sm_reg;
            end
        end

        assign p_w[s+1]    = p_reg;
        assign t_w[s+1]    = t_reg;
        assign side_w[s+1] = side_reg;
        assign v_w[s+1]    = vr_reg;
    end

    // Clamp a negative polynomial to zero
    assign out_p     = p_w[STEPS][PS_W-1] ? '0 : P_W'(p_w[STEPS]);
    assign out_valid = v_w[STEPS];
    assign out_side  = side_w[STEPS];

endmodule

// ----- rtl/erf_exp.sv -----
module erf_exp #(
    parameter int IN_FRAC_BITS = erf_pkg::IN_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [erf_pkg::MAG_W-1:0] in_mag,
    input  erf_pkg::erf_carry_t       in_carry,
    output logic                      out_valid,
    output logic [erf_pkg::T_W-1:0]   out_e,
    output erf_pkg::erf_carry_t       out_carry
);
    import erf_pkg::*;

    localparam int SH    = 2 * IN_FRAC_BITS - FX_FRAC;
    localparam int SH_P  = (SH > 0) ? SH : 0;
    localparam int SH_N  = (SH < 0) ? -SH : 0;
    localparam logic [63:0] SQ_RND = (64'd1 << SH_P) >> 1;
    localparam logic [63:0] SQ_LIM = 64'd32 << (2 * IN_FRAC_BITS);
    localparam int A_W   = R_W + T_W;
    localparam int B_W   = R_W + M_W;
    localparam int SQR_W = 2 * T_W;

    logic [2*MAG_W-1:0] sq;
    logic [63:0]        sq64;
    logic [63:0]        s64;
    logic               big;
    erf_carry_t         carry_next;

    logic               v0_reg;
    logic [R_W-1:0]     r0_reg;
    erf_carry_t         c0_reg;

    logic [T_W-1:0]     q_w [0:EXP_TERMS+SQUARINGS];
    logic [R_W-1:0]     r_w [0:EXP_TERMS];
    erf_carry_t         c_w [0:EXP_TERMS+SQUARINGS];
    logic               v_w [0:EXP_TERMS+SQUARINGS];

    // Square the magnitude, flag large arguments, bring x*x to Q30
    assign sq   = (2*MAG_W)'(in_mag) * (2*MAG_W)'(in_mag);
    assign sq64 = 64'(sq);
    assign big  = sq64 >= SQ_LIM;
    assign s64  = (SH >= 0) ? ((sq64 + SQ_RND) >> SH_P) : (sq64 << SH_N);

    // Tag the transaction with the large-argument flag
    assign carry_next.neg = in_carry.neg;
    assign carry_next.big = big;
    assign carry_next.p   = in_carry.p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg <= R_W'(s64 >> EXP_PRE_SHIFT);
            c0_reg <= carry_next;
        end
    end

    assign q_w[0] = FX_ONE;
    assign r_w[0] = r0_reg;
    assign c_w[0] = c0_reg;
    assign v_w[0] = v0_reg;

    // Taylor terms from k = 8 down to 1: multiply, scale by 1/k, subtract from one
    for (genvar i = 0; i < EXP_TERMS; i++)
    begin : g_term
        localparam int K   = EXP_TERMS - i;
        localparam int SHF = recip_shift(K);
        localparam logic [M_W-1:0] MK = recip_mult(K);

        logic             va_reg, vb_reg, vc_reg;
        logic [A_W-1:0]   pa_reg;
        logic [B_W-1:0]   pb_reg;
        logic [T_W-1:0]   qc_reg;
        logic [R_W-1:0]   ra_reg, rb_reg, rc_reg;
        erf_carry_t       ca_reg, cb_reg, cc_reg;
        logic [R_W-1:0]   vround;

        assign vround = R_W'((64'(pa_reg) + FX_HALF) >> FX_FRAC);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
            end
            else if (adv)
            begin
                va_reg <= v_w[i];
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pa_reg <= A_W'(r_w[i]) * A_W'(q_w[i]);
                ra_reg <= r_w[i];
                ca_reg <= c_w[i];
                pb_reg <= B_W'(vround) * B_W'(MK);
                rb_reg <= ra_reg;
                cb_reg <= ca_reg;
                qc_reg <= FX_ONE - T_W'(pb_reg >> SHF);
                rc_reg <= rb_reg;
                cc_reg <= cb_reg;
            end
        end

        assign q_w[i+1] = qc_reg;
        assign r_w[i+1] = rc_reg;
        assign c_w[i+1] = cc_reg;
        assign v_w[i+1] = vc_reg;
    end

    // Undo the argument reduction by repeated squaring
    for (genvar j = 0; j < SQUARINGS; j++)
    begin : g_square
        localparam int N = EXP_TERMS + j;

        logic             vs_reg;
        logic [T_W-1:0]   qs_reg;
        erf_carry_t       cs_reg;
        logic [SQR_W-1:0] qq;

        assign qq = SQR_W'(q_w[N]) * SQR_W'(q_w[N]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs_reg <= 1'b0;
            end
            else if (adv)
            begin
                vs_reg <= v_w[N];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                qs_reg <= T_W'((64'(qq) + FX_HALF) >> FX_FRAC);
                cs_reg <= c_w[N];
            end
        end

        assign q_w[N+1] = qs_reg;
        assign c_w[N+1] = cs_reg;
        assign v_w[N+1] = vs_reg;
    end

    // Force exp(-x*x) to zero for large arguments
    assign out_carry = c_w[EXP_TERMS+SQUARINGS];
    assign out_valid = v_w[EXP_TERMS+SQUARINGS];
    assign out_e     = out_carry.big ? '0 : q_w[EXP_TERMS+SQUARINGS];

endmodule

// ----- rtl/erf_approximation.sv -----
// erf(x) by the Abramowitz-Stegun 7.1.26 approximation in fixed point. The argument
// arg_value is signed Q3.IN_FRAC_BITS and erf_value is signed with OUT_FRAC_BITS
// fraction bits, saturated to +-32767 and odd-symmetric about zero. One transaction
// is accepted per clock while arg_stall is low. The argument register takes the
// transaction; behind it sit the 32-stage reciprocal divider (a load stage, then one
// quotient bit per stage), ten Horner stages, a 31-stage exponential (an argument
// stage, eight Taylor terms of three stages and six squarings) and the product and
// output registers. A two-entry output buffer (output register and skid entry)
// holds one more result while a result waits on erf_stall; arg_stall rises only once
// that buffer is full.
module erf_approximation #(
    parameter int IN_FRAC_BITS  = erf_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = erf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              arg_valid,
    output logic                              arg_stall,
    input  logic signed [erf_pkg::OUT_W-1:0]  arg_value,
    output logic                              erf_valid,
    input  logic                              erf_stall,
    output logic signed [erf_pkg::OUT_W-1:0]  erf_value
);
    import erf_pkg::*;

    localparam int OSH = FX_FRAC - OUT_FRAC_BITS;
    localparam logic [63:0] O_RND = (64'd1 << OSH) >> 1;
    localparam int F_W = P_W + T_W;

    logic                adv;

    logic                in_valid_reg;
    erf_side_t           in_side_reg;
    erf_side_t           side_next;

    logic                rc_valid;
    logic [T_W-1:0]      rc_t;
    erf_side_t           rc_side;

    logic                pl_valid;
    logic [P_W-1:0]      pl_p;
    erf_side_t           pl_side;
    erf_carry_t          pl_carry;

    logic                ex_valid;
    logic [T_W-1:0]      ex_e;
    erf_carry_t          ex_carry;

    logic                f_valid_reg;
    logic [F_W-1:0]      f_prod_reg;
    logic                f_neg_reg;

    logic [63:0]         pr;
    logic [63:0]         res;
    logic [63:0]         val;
    logic [OUT_W-1:0]    sat;
    logic [OUT_W-1:0]    result;

    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0]    skid_data_reg;
    logic                skid_load;

    // Freeze the pipeline only while the output buffer is full
    assign adv       = !skid_valid_reg;
    assign arg_stall = skid_valid_reg;

    // Split the argument into sign and magnitude
    assign side_next.neg = arg_value[OUT_W-1];
    assign side_next.mag = arg_value[OUT_W-1] ? MAG_W'(-$signed(MAG_W'(arg_value)))
                                              : MAG_W'(arg_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= arg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_side_reg <= side_next;
        end
    end

    erf_recip #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid_reg),
        .in_side  (in_side_reg),
        .out_valid(rc_valid),
        .out_t    (rc_t),
        .out_side (rc_side)
    );

    erf_poly u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (rc_valid),
        .in_t     (rc_t),
        .in_side  (rc_side),
        .out_valid(pl_valid),
        .out_p    (pl_p),
        .out_side (pl_side)
    );

    assign pl_carry.neg = pl_side.neg;
    assign pl_carry.big = 1'b0;
    assign pl_carry.p   = pl_p;

    erf_exp #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (pl_valid),
        .in_mag   (pl_side.mag),
        .in_carry (pl_carry),
        .out_valid(ex_valid),
        .out_e    (ex_e),
        .out_carry(ex_carry)
    );

    // Polynomial times exponential
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= ex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_prod_reg <= F_W'(ex_carry.p) * F_W'(ex_e);
            f_neg_reg  <= ex_carry.neg;
        end
    end

    // Subtract from one, round to the output format, saturate, restore the sign
    assign pr     = (64'(f_prod_reg) + FX_HALF) >> FX_FRAC;
    assign res    = (pr >= FX_ONE64) ? 64'd0 : (FX_ONE64 - pr);
    assign val    = (res + O_RND) >> OSH;
    assign sat    = (val > 64'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(val);
    assign result = f_neg_reg ? OUT_W'(-$signed(sat)) : sat;

    // Output register with a skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (!erf_stall)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (f_valid_reg)
        begin
            if (!out_valid_reg || !erf_stall)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_load       = 1'b1;
            end
        end
        else if (!erf_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (skid_load)
        begin
            skid_data_reg <= result;
        end
    end

    assign erf_valid = out_valid_reg;
    assign erf_value = $signed(out_data_reg);

endmodule

// ----- rtl/erf_checker.sv -----
module erf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              arg_valid,
    input logic                              arg_stall,
    input logic signed [erf_pkg::OUT_W-1:0]  arg_value,
    input logic                              erf_valid,
    input logic                              erf_stall,
    input logic signed [erf_pkg::OUT_W-1:0]  erf_value
);
    import erf_pkg::*;

    // Saturation never produces the most negative code
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        erf_valid |-> (erf_value != 16'sh8000))
        else $error("erf_value took the most negative code");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (erf_valid && erf_stall) |=> (erf_valid && $stable(erf_value)))
        else $error("stalled result changed");

    // With nothing waiting at the output, the input is never stalled
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !erf_valid |-> !arg_stall)
        else $error("input stalled with an empty output");

    // A full buffer stays full while the output is stalled
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (arg_stall && erf_stall) |=> arg_stall)
        else $error("buffer drained under output stall");

endmodule

bind erf_approximation erf_checker u_erf_checker (.*);
